FILE: hw/rtl/lne_pkg.sv
// Line editor package: line depth, widths, result kinds, escape codes,
// and the control word that steers the row of line cells.
// No dependencies.
package lne_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

    // Fixed key codes of the arrow sequences
    localparam logic [7:0] ESC_CODE     = 8'h1B;
    localparam logic [7:0] BRACKET_CODE = 8'h5B;
    localparam logic [7:0] LEFT_CODE    = 8'h44;
    localparam logic [7:0] RIGHT_CODE   = 8'h43;

    // Reset values of the configuration registers
    localparam logic [7:0] ENTER_RESET     = 8'd13;
    localparam logic [7:0] BACKSPACE_RESET = 8'd8;

    // Register indexes on the configuration port
    localparam logic REG_ENTER     = 1'b0;
    localparam logic REG_BACKSPACE = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2,
        KIND_DROP = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_SEEN = 2'd1,
        ESC_CSI  = 2'd2
    } esc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARROW_BR,
        ST_ARROW_FIN,
        ST_EMIT
    } state_t;

    // Cell operations: insert opens a gap at pos, delete closes the gap at pos
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [LEN_W-1:0] pos;
        logic [7:0]       din;
    } chain_ctl_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] cursor;
        logic             busy;
    } lne_status_t;

endpackage

FILE: hw/rtl/lne_cell.sv
// One cell of the edit line: holds one byte and trades it with its neighbors.
// Depends on lne_pkg.
module lne_cell (
    input  logic                    clk,
    input  lne_pkg::chain_ctl_t     ctl,
    input  logic [lne_pkg::LEN_W-1:0] idx,
    input  logic [7:0]              left_byte,
    input  logic [7:0]              right_byte,
    output logic [7:0]              byte_q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Insert: cell at pos takes the new byte, cells above take the left one.
    // Delete: cells from pos up take the right one.
    always_comb
    begin
        byte_next = byte_reg;
        unique case (ctl.op)
            lne_pkg::OP_INSERT:
            begin
                if (idx == ctl.pos)
                    byte_next = ctl.din;
                else if (idx > ctl.pos)
                    byte_next = left_byte;
            end
            lne_pkg::OP_DELETE:
            begin
                if (idx >= ctl.pos)
                    byte_next = right_byte;
            end
            default: byte_next = byte_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

FILE: hw/rtl/lne_ctrl.sv
// Line editor control: escape decoding, length and cursor, result sequencing
// and the output word register. Depends on lne_pkg.
module lne_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            enter_code,
    input  logic [7:0]            backspace_code,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_kind,
    output logic [7:0]            out_data,
    output logic                  out_last,
    input  logic [7:0]            head_byte,
    output lne_pkg::chain_ctl_t   ctl,
    output lne_pkg::lne_status_t  status
);

    localparam int LW = lne_pkg::LEN_W;

    lne_pkg::state_t state_reg, state_next;
    lne_pkg::esc_t   esc_reg, esc_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   cur_reg, cur_next;
    logic [LW-1:0]   rem_reg, rem_next;
    logic [7:0]      arrow_reg, arrow_next;

    logic            valid_reg;
    logic [1:0]      kind_reg;
    logic [7:0]      data_reg;
    logic            last_reg;

    logic            slot_free;
    logic            accept;
    logic            arrow_left;
    logic            arrow_right;
    logic            arrow_go;
    logic            enter_go;

    logic            load;
    lne_pkg::kind_t  load_kind;
    logic [7:0]      load_data;
    logic            load_last;

    // Handshake and byte decode
    assign slot_free   = !valid_reg || out_ready;
    assign in_ready    = (state_reg == lne_pkg::ST_IDLE) && slot_free;
    assign accept      = in_valid && in_ready;
    assign arrow_left  = (esc_reg == lne_pkg::ESC_CSI) && (rx_byte == lne_pkg::LEFT_CODE)
                         && (cur_reg != '0);
    assign arrow_right = (esc_reg == lne_pkg::ESC_CSI) && (rx_byte == lne_pkg::RIGHT_CODE)
                         && (cur_reg < len_reg);
    assign arrow_go    = arrow_left || arrow_right;
    assign enter_go    = (esc_reg == lne_pkg::ESC_IDLE) && (rx_byte != lne_pkg::ESC_CODE)
                         && (rx_byte == enter_code);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lne_pkg::ST_IDLE:
            begin
                if (accept && arrow_go)
                    state_next = lne_pkg::ST_ARROW_BR;
                else if (accept && enter_go)
                    state_next = lne_pkg::ST_EMIT;
            end
            lne_pkg::ST_ARROW_BR:
            begin
                if (slot_free)
                    state_next = lne_pkg::ST_ARROW_FIN;
            end
            lne_pkg::ST_ARROW_FIN:
            begin
                if (slot_free)
                    state_next = lne_pkg::ST_IDLE;
            end
            lne_pkg::ST_EMIT:
            begin
                if (slot_free && rem_reg == '0)
                    state_next = lne_pkg::ST_IDLE;
            end
            default: state_next = lne_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates, cell control and result words
    always_comb
    begin
        esc_next   = esc_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        arrow_next = arrow_reg;
        ctl.op     = lne_pkg::OP_HOLD;
        ctl.pos    = cur_reg;
        ctl.din    = rx_byte;
        load       = 1'b0;
        load_kind  = lne_pkg::KIND_ECHO;
        load_data  = 8'h00;
        load_last  = 1'b0;
        unique case (state_reg)
            lne_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (esc_reg)
                        lne_pkg::ESC_SEEN:
                        begin
                            esc_next = (rx_byte == lne_pkg::BRACKET_CODE) ?
                                       lne_pkg::ESC_CSI : lne_pkg::ESC_IDLE;
                        end
                        lne_pkg::ESC_CSI:
                        begin
                            esc_next = lne_pkg::ESC_IDLE;
                            if (arrow_go)
                            begin
                                cur_next   = arrow_left ? cur_reg - 1'b1 : cur_reg + 1'b1;
                                arrow_next = rx_byte;
                                load       = 1'b1;
                                load_data  = lne_pkg::ESC_CODE;
                            end
                        end
                        default:
                        begin
                            priority if (rx_byte == lne_pkg::ESC_CODE)
                                esc_next = lne_pkg::ESC_SEEN;
                            else if (rx_byte == enter_code)
                                rem_next = len_reg;
                            else if (rx_byte == backspace_code)
                            begin
                                if (cur_reg != '0)
                                begin
                                    ctl.op    = lne_pkg::OP_DELETE;
                                    ctl.pos   = cur_reg - 1'b1;
                                    len_next  = len_reg - 1'b1;
                                    cur_next  = cur_reg - 1'b1;
                                    load      = 1'b1;
                                    load_data = backspace_code;
                                    load_last = 1'b1;
                                end
                            end
                            else if (len_reg == LW'(lne_pkg::LINE_DEPTH))
                            begin
                                load      = 1'b1;
                                load_kind = lne_pkg::KIND_DROP;
                                load_last = 1'b1;
                            end
                            else
                            begin
                                ctl.op    = lne_pkg::OP_INSERT;
                                len_next  = len_reg + 1'b1;
                                cur_next  = cur_reg + 1'b1;
                                load      = 1'b1;
                                load_data = rx_byte;
                                load_last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            lne_pkg::ST_ARROW_BR:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    load_data = lne_pkg::BRACKET_CODE;
                end
            end
            lne_pkg::ST_ARROW_FIN:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    load_data = arrow_reg;
                    load_last = 1'b1;
                end
            end
            lne_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    load = 1'b1;
                    if (rem_reg != '0)
                    begin
                        // Head cell goes out, the row shifts down by one
                        load_kind = lne_pkg::KIND_LINE;
                        load_data = head_byte;
                        ctl.op    = lne_pkg::OP_DELETE;
                        ctl.pos   = '0;
                        rem_next  = rem_reg - 1'b1;
                    end
                    else
                    begin
                        load_kind = lne_pkg::KIND_END;
                        load_last = 1'b1;
                        len_next  = '0;
                        cur_next  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lne_pkg::ST_IDLE;
            esc_reg   <= lne_pkg::ESC_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        arrow_reg <= arrow_next;
        if (load)
        begin
            kind_reg <= load_kind;
            data_reg <= load_data;
            last_reg <= load_last;
        end
    end

    assign out_valid     = valid_reg;
    assign out_kind      = kind_reg;
    assign out_data      = data_reg;
    assign out_last      = last_reg;
    assign status.len    = len_reg;
    assign status.cursor = cur_reg;
    assign status.busy   = (state_reg != lne_pkg::ST_IDLE);

endmodule

FILE: hw/rtl/serial_console_line_editor_top.sv
// Serial console line editor top level: configuration registers, the row of
// line cells and the control unit. Depends on lne_pkg, lne_cell, lne_ctrl.
//
// Takes one console byte per word and keeps an edit line of up to 32 bytes
// in a row of byte cells that shift as a unit. A plain byte is inserted at
// the cursor and echoed, backspace deletes before the cursor, ESC [ D and
// ESC [ C move the cursor, and enter sends the line (kind 1 words, then an
// end word of kind 2) and clears it. An arrow key that moves the cursor
// echoes three words, and on enter the line leaves the head cell one byte
// per cycle while the output register is free and the row shifts down.
// Input is taken only when the previous byte's words are all loaded into
// the output register.
// Registers: 0x0 enter code (reset 13), 0x4 backspace code (reset 8).
module serial_console_line_editor_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    localparam int LW = lne_pkg::LEN_W;

    logic [7:0]           enter_reg;
    logic [7:0]           backspace_reg;
    logic                 reg_sel;
    lne_pkg::chain_ctl_t  ctl;
    lne_pkg::lne_status_t status;
    logic [7:0]           cell_q [lne_pkg::LINE_DEPTH];

    // Configuration registers; the word offset alone selects the register
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_reg     <= lne_pkg::ENTER_RESET;
            backspace_reg <= lne_pkg::BACKSPACE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (reg_sel == lne_pkg::REG_ENTER)
                enter_reg <= pwdata[7:0];
            else
                backspace_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = {24'h000000, (reg_sel == lne_pkg::REG_ENTER) ? enter_reg : backspace_reg};
        if (paddr[1:0] != 2'b00)
            prdata = 32'h0;
    end

    // Row of line cells
    genvar g;
    generate
        for (g = 0; g < lne_pkg::LINE_DEPTH; g++)
        begin : g_cell
            logic [7:0] left_byte;
            logic [7:0] right_byte;
            if (g == 0)
            begin : g_first
                assign left_byte = 8'h00;
            end
            else
            begin : g_mid
                assign left_byte = cell_q[g-1];
            end
            if (g == lne_pkg::LINE_DEPTH - 1)
            begin : g_last
                assign right_byte = 8'h00;
            end
            else
            begin : g_inner
                assign right_byte = cell_q[g+1];
            end
            lne_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .idx        (LW'(g)),
                .left_byte  (left_byte),
                .right_byte (right_byte),
                .byte_q     (cell_q[g])
            );
        end
    endgenerate

    // Control unit
    lne_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .enter_code     (enter_reg),
        .backspace_code (backspace_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .rx_byte        (s_tdata),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (m_tuser),
        .out_data       (m_tdata),
        .out_last       (m_tlast),
        .head_byte      (cell_q[0]),
        .ctl            (ctl),
        .status         (status)
    );

    // Cursor never passes the end of the line
    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        status.cursor <= status.len)
        else $error("cursor beyond line length");

    // Line never grows past the cell row
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.len <= LW'(lne_pkg::LINE_DEPTH))
        else $error("line length beyond depth");

    // An end word leaves an empty line behind
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser == lne_pkg::KIND_END && !status.busy)
        |-> (status.len == '0))
        else $error("line not cleared after end word");

    // Input is never taken while a multi-word sequence is running
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !s_tready)
        else $error("input taken while busy");

endmodule
